// File: hdl/rotation_matrix_to_euler_macros.svh
// assertion macros for the euler angle block
`ifndef ROTATION_MATRIX_TO_EULER_MACROS_SVH
`define ROTATION_MATRIX_TO_EULER_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define RME_ASSERT_IMP(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define RME_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

// File: hdl/rme_pkg.sv
// constants, types and tables for the euler angle block
package rme_pkg;
  localparam int FRAC_BITS = 16;
  localparam int ANG_FRAC = 30;
  localparam int ITERS = 31;
  localparam int IN_W = 18;
  localparam int OUT_W = 20;
  localparam int SUM_W = 37;
  localparam int SQ_W = 19;
  // cordic x/y datapath: 20-bit operand scaled by 2^30 grows by under 2 bits
  localparam int CW = 54;
  localparam int ZW = 34;
  localparam logic [ZW-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic [1:0] REG_THRESHOLD = 2'd0;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  function automatic logic [ZW-1:0] atan_tab(input int i);
    logic [ZW-1:0] t;
    unique case (i)
      0: t = 34'h3243F6A8; 1: t = 34'h1DAC6705; 2: t = 34'h0FADBAFC;
      3: t = 34'h07F56EA6; 4: t = 34'h03FEAB76; 5: t = 34'h01FFD55B;
      6: t = 34'h00FFFAAA; 7: t = 34'h007FFF55; 8: t = 34'h003FFFEA;
      9: t = 34'h001FFFFD; 10: t = 34'h000FFFFF; 11: t = 34'h0007FFFF;
      12: t = 34'h0003FFFF; 13: t = 34'h0001FFFF; 14: t = 34'h0000FFFF;
      15: t = 34'h00007FFF; 16: t = 34'h00003FFF; 17: t = 34'h00001FFF;
      18: t = 34'h00000FFF; 19: t = 34'h000007FF; 20: t = 34'h000003FF;
      21: t = 34'h000001FF; 22: t = 34'h000000FF; 23: t = 34'h0000007F;
      24: t = 34'h0000003F; 25: t = 34'h0000001F; 26: t = 34'h0000000F;
      27: t = 34'h00000008; 28: t = 34'h00000004; 29: t = 34'h00000002;
      30: t = 34'h00000001;
      default: t = '0;
    endcase
    return t;
  endfunction

  // one cordic vectoring rotation
  function automatic cordic_t cordic_step(input cordic_t c, input int i);
    cordic_t r;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    xs = c.x >>> i;
    ys = c.y >>> i;
    if (!c.y[CW-1]) begin
      r.x = c.x + ys;
      r.y = c.y - xs;
      r.z = c.z + atan_tab(i);
    end else begin
      r.x = c.x - ys;
      r.y = c.y + xs;
      r.z = c.z - atan_tab(i);
    end
    return r;
  endfunction

  // set up the rotation: fold left half plane, scale by 2^30
  function automatic cordic_t cordic_init(input logic signed [OUT_W-1:0] y,
                                          input logic signed [OUT_W-1:0] x);
    cordic_t r;
    logic signed [OUT_W:0] xe;
    logic signed [OUT_W:0] ye;
    xe = OUT_W'(x) == '0 ? '0 : {x[OUT_W-1], x};
    ye = {y[OUT_W-1], y};
    r.z = '0;
    if (x[OUT_W-1]) begin
      xe = -{x[OUT_W-1], x};
      ye = -{y[OUT_W-1], y};
      r.z = y[OUT_W-1] ? -PI_Q30 : PI_Q30;
    end
    r.x = CW'(xe) <<< ANG_FRAC;
    r.y = CW'(ye) <<< ANG_FRAC;
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] angle_out(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] r;
    r = (z + ZW'(1 << (ANG_FRAC - FRAC_BITS - 1))) >>> (ANG_FRAC - FRAC_BITS);
    if (r > ZW'(524287)) r = ZW'(524287);
    if (r < -ZW'(524288)) r = -ZW'(524288);
    return r[OUT_W-1:0];
  endfunction
endpackage

// File: hdl/rotation_matrix_to_euler.sv
// Euler angles (zyx) from a rotation matrix, one word per cycle while the
// output is not stalled. The stages are a register for the squares, a
// restoring square root (one result bit per stage), then 31 cordic stages
// for all three atan2 units in parallel, one rotation each, and an output
// register. A stall holds the whole pipeline, output register included,
// until the waiting result is taken. Nothing needs clearing after reset.
`include "rotation_matrix_to_euler_macros.svh"
module rotation_matrix_to_euler (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_tvalid,
  output logic         s_tready,
  // m00, m10, m20, m21, m22, m12, m11 (18 bits each), 2 zero bits
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // roll, pitch, yaw (20 bits each), 4 zero bits
  output logic [63:0]  m_tdata,
  // singular
  output logic         m_tuser
);
  import rme_pkg::*;

  localparam int SQ_STAGES = SQ_W;
  localparam int NST = 1 + SQ_STAGES + ITERS;

  logic [15:0] singular_threshold;
  logic advance;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_THRESHOLD) ? {16'd0, singular_threshold} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      singular_threshold <= 16'd1;
    end else if (psel && penable && pwrite && paddr == REG_THRESHOLD) begin
      singular_threshold <= pwdata[15:0];
    end
  end

  // stage valid bits
  logic [NST-1:0] vld;
  assign advance = !m_tvalid || m_tready;
  assign s_tready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[NST-2:0], s_tvalid};
    end
  end

  // stage 0: squares and operand capture
  logic signed [IN_W-1:0] a_m00, a_m10, a_m20, a_r_y, a_r_x, a_s_y, a_s_x;
  logic [SUM_W-1:0] a_sum;
  always_ff @(posedge clk) begin
    if (advance) begin
      a_m00 <= s_tdata[17:0];
      a_m10 <= s_tdata[35:18];
      a_m20 <= s_tdata[53:36];
      a_r_y <= s_tdata[71:54];
      a_r_x <= s_tdata[89:72];
      a_s_y <= s_tdata[107:90];
      a_s_x <= s_tdata[125:108];
      a_sum <= SUM_W'($signed(s_tdata[17:0]) * $signed(s_tdata[17:0]))
             + SUM_W'($signed(s_tdata[35:18]) * $signed(s_tdata[35:18]));
    end
  end

  // square root pipeline, one root bit per stage
  logic [SUM_W-1:0] sq_rem [SQ_STAGES+1];
  logic [SQ_W-1:0]  sq_root [SQ_STAGES+1];
  logic signed [IN_W-1:0] q_m00 [SQ_STAGES+1], q_m10 [SQ_STAGES+1],
    q_m20 [SQ_STAGES+1], q_ry [SQ_STAGES+1], q_rx [SQ_STAGES+1],
    q_sy [SQ_STAGES+1], q_sx [SQ_STAGES+1];

  assign sq_rem[0] = a_sum;
  assign sq_root[0] = '0;
  assign q_m00[0] = a_m00; assign q_m10[0] = a_m10; assign q_m20[0] = a_m20;
  assign q_ry[0] = a_r_y; assign q_rx[0] = a_r_x;
  assign q_sy[0] = a_s_y; assign q_sx[0] = a_s_x;

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    localparam int B = SQ_STAGES - 1 - k;
    logic [SQ_W-1:0] trial;
    logic [SUM_W+1:0] tsq;
    always_comb begin
      trial = sq_root[k] | (SQ_W'(1) << B);
      // (r + 2^b)^2 - r^2 = 2^(b+1) r + 2^(2b), r has only higher bits
      tsq = ((SUM_W+2)'(sq_root[k]) << (B + 1)) + ((SUM_W+2)'(1) << (2 * B));
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        if ((SUM_W+2)'(sq_rem[k]) >= tsq) begin
          sq_rem[k+1] <= sq_rem[k] - tsq[SUM_W-1:0];
          sq_root[k+1] <= trial;
        end else begin
          sq_rem[k+1] <= sq_rem[k];
          sq_root[k+1] <= sq_root[k];
        end
        q_m00[k+1] <= q_m00[k]; q_m10[k+1] <= q_m10[k];
        q_m20[k+1] <= q_m20[k]; q_ry[k+1] <= q_ry[k]; q_rx[k+1] <= q_rx[k];
        q_sy[k+1] <= q_sy[k]; q_sx[k+1] <= q_sx[k];
      end
    end
  end

  // branch select and cordic setup, combinational into the first rotation
  logic [SQ_W-1:0] sy;
  logic sing_c;
  logic signed [OUT_W-1:0] ry, rx, py, px, yy, yx;
  logic zero_r, zero_p, zero_y;
  assign sy = sq_root[SQ_STAGES];
  assign sing_c = sy < SQ_W'(singular_threshold);
  always_comb begin
    ry = sing_c ? -OUT_W'(q_sy[SQ_STAGES]) : OUT_W'(q_ry[SQ_STAGES]);
    rx = sing_c ? OUT_W'(q_sx[SQ_STAGES]) : OUT_W'(q_rx[SQ_STAGES]);
    py = -OUT_W'(q_m20[SQ_STAGES]);
    px = OUT_W'(sy);
    yy = OUT_W'(q_m10[SQ_STAGES]);
    yx = OUT_W'(q_m00[SQ_STAGES]);
    zero_r = (ry == '0) && (rx == '0);
    zero_p = (py == '0) && (px == '0);
    zero_y = sing_c || ((yy == '0) && (yx == '0));
  end

  cordic_t cr [ITERS+1], cp [ITERS+1], cy [ITERS+1];
  logic [2:0] zf [ITERS+1];
  logic sg [ITERS+1];
  assign cr[0] = cordic_init(ry, rx);
  assign cp[0] = cordic_init(py, px);
  assign cy[0] = cordic_init(yy, yx);
  assign zf[0] = {zero_y, zero_p, zero_r};
  assign sg[0] = sing_c;

  for (genvar i = 0; i < ITERS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (advance) begin
        cr[i+1] <= cordic_step(cr[i], i);
        cp[i+1] <= cordic_step(cp[i], i);
        cy[i+1] <= cordic_step(cy[i], i);
        zf[i+1] <= zf[i];
        sg[i+1] <= sg[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= vld[NST-1];
    end
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata[19:0]  <= zf[ITERS][0] ? '0 : angle_out(cr[ITERS].z);
      m_tdata[39:20] <= zf[ITERS][1] ? '0 : angle_out(cp[ITERS].z);
      m_tdata[59:40] <= zf[ITERS][2] ? '0 : angle_out(cy[ITERS].z);
      m_tdata[63:60] <= '0;
      m_tuser <= sg[ITERS];
    end
  end

  `RME_ASSERT_NEXT(a_stall_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `RME_ASSERT_IMP(a_ready, clk, rst, !m_tvalid, s_tready)
  `RME_ASSERT_NEXT(a_valid_out, clk, rst, advance && vld[NST-1], m_tvalid)
endmodule
